FILE: hw/rtl/counting_semaphore_table_core_macros.svh
// Assertion helpers shared by the semaphore table.
`ifndef COUNTING_SEMAPHORE_TABLE_CORE_MACROS_SVH
`define COUNTING_SEMAPHORE_TABLE_CORE_MACROS_SVH

// Consequent checked in the same cycle.
`define CST_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the next cycle.
`define CST_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/cst_pkg.sv
package cst_pkg;

    localparam int CNT_W  = 16;
    localparam int PROC_W = 4;
    localparam int SID_W  = 3;
    localparam int CMD_W  = 2;
    localparam int STAT_W = 2;

    localparam logic signed [CNT_W-1:0] CNT_MIN = {1'b1, {(CNT_W-1){1'b0}}};
    localparam logic signed [CNT_W-1:0] CNT_MAX = {1'b0, {(CNT_W-1){1'b1}}};
    localparam logic signed [CNT_W-1:0] CNT_ONE = CNT_W'(1);

    localparam logic [CMD_W-1:0] CMD_ALLOC  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_WAIT   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SIGNAL = 2'd2;

    localparam logic [STAT_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_NO_FREE   = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_NOT_ALLOC = 2'd2;
    localparam logic [STAT_W-1:0] STATUS_FULL      = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic capture;
        logic execute;
        logic publish;
    } ctrl_t;

    typedef struct packed {
        logic out_pending;
        logic out_taken;
    } dp_stat_t;

endpackage

FILE: hw/rtl/cst_ctrl.sv
module cst_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  cst_pkg::dp_stat_t stat,
    output cst_pkg::ctrl_t    ctrl
);

    cst_pkg::state_t state_reg;
    cst_pkg::state_t state_next;
    logic            out_free;

    assign out_free = !stat.out_pending || stat.out_taken;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= cst_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            cst_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = cst_pkg::ST_EXEC;
                end
            end
            cst_pkg::ST_EXEC:
            begin
                state_next = cst_pkg::ST_DONE;
            end
            cst_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = cst_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = cst_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_stall     = 1'b1;
        ctrl.capture = 1'b0;
        ctrl.execute = 1'b0;
        ctrl.publish = 1'b0;
        unique case (state_reg)
            cst_pkg::ST_IDLE:
            begin
                in_stall     = 1'b0;
                ctrl.capture = in_valid;
            end
            cst_pkg::ST_EXEC:
            begin
                ctrl.execute = 1'b1;
            end
            cst_pkg::ST_DONE:
            begin
                // hold the result until the output register frees up
                ctrl.publish = out_free;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

endmodule

FILE: hw/rtl/cst_dp.sv
module cst_dp #(
    parameter int NUM_SEMS  = 8,
    parameter int NUM_PROCS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  cst_pkg::ctrl_t                    ctrl,
    output cst_pkg::dp_stat_t                 stat,
    input  logic [cst_pkg::CMD_W-1:0]         command,
    input  logic [cst_pkg::SID_W-1:0]         sem_id,
    input  logic signed [cst_pkg::CNT_W-1:0]  init_value,
    input  logic [cst_pkg::PROC_W-1:0]        proc_id,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [cst_pkg::STAT_W-1:0]        status,
    output logic [cst_pkg::SID_W-1:0]         alloc_id,
    output logic                              blocked,
    output logic                              wake_valid,
    output logic [cst_pkg::PROC_W-1:0]        wake_proc
);

    localparam int SEM_W     = (NUM_SEMS > 1) ? $clog2(NUM_SEMS) : 1;
    localparam int PTR_W     = $clog2(NUM_PROCS);
    localparam int FILL_W    = $clog2(NUM_PROCS + 1);
    localparam int MEM_DEPTH = NUM_SEMS * NUM_PROCS;
    localparam int MEM_AW    = $clog2(MEM_DEPTH);

    // captured beat
    logic [cst_pkg::CMD_W-1:0]        cmd_reg;
    logic [cst_pkg::SID_W-1:0]        sid_reg;
    logic signed [cst_pkg::CNT_W-1:0] init_reg;
    logic [cst_pkg::PROC_W-1:0]       pid_reg;

    // semaphore table
    logic [NUM_SEMS-1:0]              sem_valid_reg;
    logic signed [cst_pkg::CNT_W-1:0] sem_count_reg [NUM_SEMS];
    logic [PTR_W-1:0]                 queue_head_reg [NUM_SEMS];
    logic [PTR_W-1:0]                 queue_tail_reg [NUM_SEMS];
    logic [FILL_W-1:0]                queue_fill_reg [NUM_SEMS];

    logic [cst_pkg::PROC_W-1:0]       wait_queue [MEM_DEPTH];
    logic [cst_pkg::PROC_W-1:0]       rd_data_reg;

    // pending result
    logic [cst_pkg::STAT_W-1:0]       res_status_reg;
    logic [cst_pkg::SID_W-1:0]        res_alloc_reg;
    logic                             res_blk_reg;
    logic                             res_wv_reg;

    logic                             out_valid_reg;
    logic [cst_pkg::STAT_W-1:0]       out_status_reg;
    logic [cst_pkg::SID_W-1:0]        out_alloc_reg;
    logic                             out_blk_reg;
    logic                             out_wv_reg;
    logic [cst_pkg::PROC_W-1:0]       out_proc_reg;

    logic                             free_found;
    logic [SEM_W-1:0]                 free_idx;
    logic                             sid_in_range;
    logic [SEM_W-1:0]                 sel;
    logic                             sel_valid;
    logic signed [cst_pkg::CNT_W-1:0] cur_count;
    logic signed [cst_pkg::CNT_W-1:0] dec_count;
    logic signed [cst_pkg::CNT_W-1:0] inc_count;
    logic [PTR_W-1:0]                 head_cur;
    logic [PTR_W-1:0]                 tail_cur;
    logic [FILL_W-1:0]                fill_cur;
    logic [PTR_W-1:0]                 head_adv;
    logic [PTR_W-1:0]                 tail_adv;
    logic                             queue_full;
    logic                             queue_empty;
    logic                             is_alloc;
    logic                             is_wait;
    logic                             is_signal;
    logic                             do_alloc;
    logic                             do_wait;
    logic                             do_block;
    logic                             do_signal;
    logic                             do_wake;
    logic [MEM_AW-1:0]                sem_base;
    logic [MEM_AW-1:0]                wr_addr;
    logic [MEM_AW-1:0]                rd_addr;
    logic [cst_pkg::STAT_W-1:0]       res_status_next;

    // lowest free entry wins: scan from the top down
    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = NUM_SEMS - 1; i >= 0; i--)
        begin
            if (!sem_valid_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = SEM_W'(i);
            end
        end
    end

    assign sid_in_range = 32'(sid_reg) < 32'(NUM_SEMS);
    assign sel          = SEM_W'(sid_reg);
    assign sel_valid    = sid_in_range && sem_valid_reg[sel];
    assign cur_count    = sem_count_reg[sel];
    assign dec_count    = (cur_count == cst_pkg::CNT_MIN) ? cst_pkg::CNT_MIN
                                                          : cur_count - cst_pkg::CNT_ONE;
    assign inc_count    = (cur_count == cst_pkg::CNT_MAX) ? cst_pkg::CNT_MAX
                                                          : cur_count + cst_pkg::CNT_ONE;
    assign head_cur     = queue_head_reg[sel];
    assign tail_cur     = queue_tail_reg[sel];
    assign fill_cur     = queue_fill_reg[sel];
    assign head_adv     = (head_cur == PTR_W'(NUM_PROCS - 1)) ? '0 : head_cur + PTR_W'(1);
    assign tail_adv     = (tail_cur == PTR_W'(NUM_PROCS - 1)) ? '0 : tail_cur + PTR_W'(1);
    assign queue_full   = fill_cur == FILL_W'(NUM_PROCS);
    assign queue_empty  = fill_cur == '0;

    assign is_alloc  = cmd_reg == cst_pkg::CMD_ALLOC;
    assign is_wait   = cmd_reg == cst_pkg::CMD_WAIT;
    assign is_signal = cmd_reg == cst_pkg::CMD_SIGNAL;

    assign do_alloc  = ctrl.execute && is_alloc && free_found;
    assign do_wait   = ctrl.execute && is_wait && sel_valid
                       && (!dec_count[cst_pkg::CNT_W-1] || !queue_full);
    assign do_block  = do_wait && dec_count[cst_pkg::CNT_W-1];
    assign do_signal = ctrl.execute && is_signal && sel_valid;
    assign do_wake   = do_signal && !queue_empty;

    assign sem_base = MEM_AW'(sel) * MEM_AW'(NUM_PROCS);
    assign wr_addr  = sem_base + MEM_AW'(tail_cur);
    assign rd_addr  = sem_base + MEM_AW'(head_cur);

    always_comb
    begin
        res_status_next = cst_pkg::STATUS_OK;
        priority if (is_alloc && !free_found)
        begin
            res_status_next = cst_pkg::STATUS_NO_FREE;
        end
        else if ((is_wait || is_signal) && !sel_valid)
        begin
            res_status_next = cst_pkg::STATUS_NOT_ALLOC;
        end
        else if (is_wait && dec_count[cst_pkg::CNT_W-1] && queue_full)
        begin
            res_status_next = cst_pkg::STATUS_FULL;
        end
        else
        begin
            res_status_next = cst_pkg::STATUS_OK;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.capture)
        begin
            cmd_reg  <= command;
            sid_reg  <= sem_id;
            init_reg <= init_value;
            pid_reg  <= proc_id;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sem_valid_reg <= '0;
            for (int i = 0; i < NUM_SEMS; i++)
            begin
                sem_count_reg[i]  <= '0;
                queue_head_reg[i] <= '0;
                queue_tail_reg[i] <= '0;
                queue_fill_reg[i] <= '0;
            end
        end
        else
        begin
            if (do_alloc)
            begin
                sem_valid_reg[free_idx] <= 1'b1;
                sem_count_reg[free_idx] <= init_reg;
            end
            if (do_wait)
            begin
                sem_count_reg[sel] <= dec_count;
            end
            if (do_block)
            begin
                queue_tail_reg[sel] <= tail_adv;
                queue_fill_reg[sel] <= fill_cur + FILL_W'(1);
            end
            if (do_signal)
            begin
                sem_count_reg[sel] <= inc_count;
            end
            if (do_wake)
            begin
                queue_head_reg[sel] <= head_adv;
                queue_fill_reg[sel] <= fill_cur - FILL_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_block)
        begin
            wait_queue[wr_addr] <= pid_reg;
        end
        if (do_wake)
        begin
            rd_data_reg <= wait_queue[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.execute)
        begin
            res_status_reg <= res_status_next;
            res_alloc_reg  <= do_alloc ? cst_pkg::SID_W'(free_idx) : '0;
            res_blk_reg    <= do_block;
            res_wv_reg     <= do_wake;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctrl.publish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.publish)
        begin
            out_status_reg <= res_status_reg;
            out_alloc_reg  <= res_alloc_reg;
            out_blk_reg    <= res_blk_reg;
            out_wv_reg     <= res_wv_reg;
            out_proc_reg   <= res_wv_reg ? rd_data_reg : '0;
        end
    end

    assign stat.out_pending = out_valid_reg;
    assign stat.out_taken   = out_valid_reg && !out_stall;

    assign out_valid  = out_valid_reg;
    assign status     = out_status_reg;
    assign alloc_id   = out_alloc_reg;
    assign blocked    = out_blk_reg;
    assign wake_valid = out_wv_reg;
    assign wake_proc  = out_proc_reg;

endmodule

FILE: hw/rtl/counting_semaphore_table_core.sv
// Table of NUM_SEMS counting semaphores, each with a saturating signed count and
// a FIFO of up to NUM_PROCS waiting process numbers. One command beat gives one
// result beat. A command is captured into the beat registers when accepted,
// then executed (table update and the registered read of the wait queue memory)
// into the result registers, and then published into the output register, which
// offers its result beat. The next command is accepted in the cycle after
// publish, also while the previous result still waits to be taken; a new command
// is not taken before the previous one is published. A stalled output holds the
// sequencer in publish until the pending result is taken. No clearing pass after
// reset: queue fill counts guard the wait queue memory.
`include "counting_semaphore_table_core_macros.svh"

module counting_semaphore_table_core #(
    parameter int NUM_SEMS  = 8,
    parameter int NUM_PROCS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [cst_pkg::CMD_W-1:0]         command,
    input  logic [cst_pkg::SID_W-1:0]         sem_id,
    input  logic signed [cst_pkg::CNT_W-1:0]  init_value,
    input  logic [cst_pkg::PROC_W-1:0]        proc_id,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [cst_pkg::STAT_W-1:0]        status,
    output logic [cst_pkg::SID_W-1:0]         alloc_id,
    output logic                              blocked,
    output logic                              wake_valid,
    output logic [cst_pkg::PROC_W-1:0]        wake_proc
);

    cst_pkg::ctrl_t    ctrl;
    cst_pkg::dp_stat_t stat;

    cst_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .ctrl     (ctrl)
    );

    cst_dp #(
        .NUM_SEMS  (NUM_SEMS),
        .NUM_PROCS (NUM_PROCS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .stat       (stat),
        .command    (command),
        .sem_id     (sem_id),
        .init_value (init_value),
        .proc_id    (proc_id),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .status     (status),
        .alloc_id   (alloc_id),
        .blocked    (blocked),
        .wake_valid (wake_valid),
        .wake_proc  (wake_proc)
    );

    // one command in flight: an accepted beat blocks the input the next cycle
    `CST_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall, "input open while busy")

    `CST_ASSERT_NEXT(a_publish_shows, clk, rst_n, ctrl.publish, out_valid, "published result not shown")

    // a failed command reports nothing else
    `CST_ASSERT_NOW(a_error_clean, clk, rst_n, out_valid && status != cst_pkg::STATUS_OK, !blocked && !wake_valid && alloc_id == '0, "error result carries data")

    `CST_ASSERT_NOW(a_wake_exclusive, clk, rst_n, out_valid && wake_valid, !blocked, "wake and block together")

endmodule
